// ===== sv/rcpd_pkg.sv =====
// Shared types and constants for the six-channel RC pulse decoder.
`timescale 1ns / 1ps

package rcpd_pkg;

  localparam int NUM_CH = 6;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  // Channel roles
  localparam int CH_ROLL   = 0;
  localparam int CH_PITCH  = 1;
  localparam int CH_THR    = 2;
  localparam int CH_YAW    = 3;
  localparam int CH_SWITCH = 4;
  localparam int CH_MODE   = 5;

  // Register reset values
  localparam logic [CFG_W-1:0] MIN_PULSE_RST     = 16'h3F0E;
  localparam logic [CFG_W-1:0] MID_PULSE_RST     = 16'h5F0F;
  localparam logic [CFG_W-1:0] YAW_DEADBAND_RST  = 16'h1000;
  localparam logic [CFG_W-1:0] SWITCH_OFFSET_RST = 16'h1500;

  // Switch position codes
  localparam logic [1:0] SW_POS_1 = 2'd1;
  localparam logic [1:0] SW_POS_2 = 2'd2;
  localparam logic [1:0] SW_POS_3 = 2'd3;

  typedef enum logic [IDX_W-1:0] {
    CFG_MIN_PULSE     = 2'd0,
    CFG_MID_PULSE     = 2'd1,
    CFG_YAW_DEADBAND  = 2'd2,
    CFG_SWITCH_OFFSET = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] min_pulse;
    logic [CFG_W-1:0] mid_pulse;
    logic [CFG_W-1:0] yaw_deadband;
    logic [CFG_W-1:0] switch_offset;
  } cfg_t;

  // Per-lane update strobe
  typedef struct packed {
    logic hit;
    logic falling;
  } lane_ctl_t;

  typedef logic [NUM_CH-1:0][TIME_W-1:0] width_arr_t;

  typedef struct packed {
    logic [TIME_W-1:0] throttle;
    logic [TIME_W-1:0] roll;
    logic [TIME_W-1:0] pitch;
    logic [TIME_W-1:0] yaw;
    logic [1:0]        switch_position;
    logic              auto_mode;
    logic              disarm_request;
  } result_t;

endpackage

// ===== sv/rc_pwm_six_channel_decoder.sv =====
// Top level: six capture lanes, decode merge stage and output register.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+--------------------------------------------
//  in_     | in_valid/in_ready   | edge_mask[6], pin_levels[6], timer_value[32]
//  out_    | out_valid/out_ready | throttle, roll, pitch, yaw (s32),
//          |                     | switch_position[2], auto_mode, disarm_request
//  cfg_    | cfg_we              | cfg_index[2], cfg_data[16]
//
// One edge event per cycle while in_ready is high; out_valid rises once the result is registered.
// Transfer edge: each hit lane restamps; on a falling edge it first sets width = old stamp - time.
// When the output register is free, the merge stage decodes the widths into it.
// Reset (synchronous) clears all timestamps and widths and loads register defaults.
// An output stall backs up one stage before in_ready drops.
`timescale 1ns / 1ps

module rc_pwm_six_channel_decoder
  import rcpd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [NUM_CH-1:0]        in_edge_mask,
  input  logic [NUM_CH-1:0]        in_pin_levels,
  input  logic [TIME_W-1:0]        in_timer_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [TIME_W-1:0] out_throttle,
  output logic signed [TIME_W-1:0] out_roll,
  output logic signed [TIME_W-1:0] out_pitch,
  output logic signed [TIME_W-1:0] out_yaw,
  output logic [1:0]               out_switch_position,
  output logic                     out_auto_mode,
  output logic                     out_disarm_request,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  cfg_t       cfg_r, cfg_nxt;
  logic       s1_v_r, s1_v_nxt;
  logic       out_v_r, out_v_nxt;
  result_t    res_r;
  result_t    res;
  width_arr_t widths;
  logic       in_xfer;
  logic       s1_adv;

  // Configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_PULSE:     cfg_nxt.min_pulse     = cfg_data;
        CFG_MID_PULSE:     cfg_nxt.mid_pulse     = cfg_data;
        CFG_YAW_DEADBAND:  cfg_nxt.yaw_deadband  = cfg_data;
        CFG_SWITCH_OFFSET: cfg_nxt.switch_offset = cfg_data;
      endcase
    end
  end

  // Pipeline flow control
  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_xfer) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  // Capture lanes, one per channel
  for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
    lane_ctl_t ctl;
    assign ctl.hit     = in_xfer && in_edge_mask[i];
    assign ctl.falling = !in_pin_levels[i];
    rcpd_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .now   (in_timer_value),
      .width (widths[i])
    );
  end

  // Merge lanes into controls
  rcpd_decode u_decode (
    .widths (widths),
    .cfg    (cfg_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_pulse     <= MIN_PULSE_RST;
      cfg_r.mid_pulse     <= MID_PULSE_RST;
      cfg_r.yaw_deadband  <= YAW_DEADBAND_RST;
      cfg_r.switch_offset <= SWITCH_OFFSET_RST;
      s1_v_r              <= 1'b0;
      out_v_r             <= 1'b0;
    end else begin
      cfg_r   <= cfg_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_v_r;
  assign out_throttle        = res_r.throttle;
  assign out_roll            = res_r.roll;
  assign out_pitch           = res_r.pitch;
  assign out_yaw             = res_r.yaw;
  assign out_switch_position = res_r.switch_position;
  assign out_auto_mode       = res_r.auto_mode;
  assign out_disarm_request  = res_r.disarm_request;

endmodule

// ===== sv/rcpd_lane.sv =====
// One capture lane: edge timestamp and pulse width of a single channel.
`timescale 1ns / 1ps

module rcpd_lane
  import rcpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  lane_ctl_t         ctl,
  input  logic [TIME_W-1:0] now,
  output logic [TIME_W-1:0] width
);

  logic [TIME_W-1:0] last_r, last_nxt;
  logic [TIME_W-1:0] width_r, width_nxt;

  // Falling edge closes a pulse; any edge restamps
  always_comb begin
    last_nxt  = last_r;
    width_nxt = width_r;
    if (ctl.hit) begin
      if (ctl.falling) begin
        width_nxt = last_r - now;
      end
      last_nxt = now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      width_r <= '0;
    end else begin
      last_r  <= last_nxt;
      width_r <= width_nxt;
    end
  end

  assign width = width_r;

endmodule

// ===== sv/rcpd_decode.sv =====
// Merge stage: turns the six lane widths into stick, switch and mode controls.
`timescale 1ns / 1ps

module rcpd_decode
  import rcpd_pkg::*;
(
  input  width_arr_t widths,
  input  cfg_t       cfg,
  output result_t    res
);

  logic [TIME_W-1:0]  min32;
  logic [TIME_W-1:0]  mid32;
  logic [TIME_W-1:0]  yaw_raw;
  logic signed [TIME_W:0] yaw_ext;
  logic signed [TIME_W:0] db_ext;
  logic signed [TIME_W:0] db_neg;
  logic               in_band;
  logic [CFG_W:0]     lo_thr;
  logic [CFG_W:0]     hi_thr;
  logic [1:0]         sw_pos;

  assign min32 = {{(TIME_W-CFG_W){1'b0}}, cfg.min_pulse};
  assign mid32 = {{(TIME_W-CFG_W){1'b0}}, cfg.mid_pulse};

  // Yaw offset and symmetric deadband (signed compare)
  assign yaw_raw = widths[CH_YAW] - mid32;
  assign yaw_ext = {yaw_raw[TIME_W-1], yaw_raw};
  assign db_ext  = {{(TIME_W+1-CFG_W){1'b0}}, cfg.yaw_deadband};
  assign db_neg  = -db_ext;
  assign in_band = (yaw_ext < db_ext) && (yaw_ext > db_neg);

  // Three-position switch thresholds
  assign lo_thr = {1'b0, cfg.min_pulse} + {1'b0, cfg.switch_offset};
  assign hi_thr = {1'b0, cfg.mid_pulse} + {1'b0, cfg.switch_offset};

  always_comb begin
    if (widths[CH_SWITCH] < {{(TIME_W-CFG_W-1){1'b0}}, lo_thr}) begin
      sw_pos = SW_POS_3;
    end else if (widths[CH_SWITCH] < {{(TIME_W-CFG_W-1){1'b0}}, hi_thr}) begin
      sw_pos = SW_POS_2;
    end else begin
      sw_pos = SW_POS_1;
    end
  end

  always_comb begin
    res.throttle        = widths[CH_THR] - min32;
    res.roll            = mid32 - widths[CH_ROLL];
    res.pitch           = widths[CH_PITCH] - mid32;
    res.yaw             = in_band ? '0 : yaw_raw;
    res.switch_position = sw_pos;
    res.auto_mode       = !(widths[CH_MODE] > mid32);
    res.disarm_request  = (sw_pos == SW_POS_1) && (widths[CH_THR] <= min32);
  end

endmodule

// ===== sv/rcpd_checker.sv =====
// Port-level checks for the RC pulse decoder, bound to the top level.
`timescale 1ns / 1ps

module rcpd_checker
  import rcpd_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [TIME_W-1:0] out_throttle,
  input logic signed [TIME_W-1:0] out_roll,
  input logic signed [TIME_W-1:0] out_pitch,
  input logic signed [TIME_W-1:0] out_yaw,
  input logic [1:0]               out_switch_position,
  input logic                     out_auto_mode,
  input logic                     out_disarm_request
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_throttle) && $stable(out_roll)
      && $stable(out_pitch) && $stable(out_yaw) && $stable(out_switch_position)
      && $stable(out_auto_mode) && $stable(out_disarm_request))
    else $error("stalled result changed");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Empty output register means the input side is open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // Disarm only in switch position 1, and position code is never zero
  a_disarm_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_switch_position != 2'd0)
      && (!out_disarm_request || out_switch_position == SW_POS_1))
    else $error("bad switch position or disarm");

endmodule

bind rc_pwm_six_channel_decoder rcpd_checker u_rcpd_checker (.*);

// ===== dv/tb_rc_pwm_six_channel_decoder.sv =====
// Self-checking testbench for the six-channel RC pulse capture and decode block.
`timescale 1ns / 1ps

module tb_rc_pwm_six_channel_decoder;
  import rcpd_pkg::*;

  typedef struct packed {
    logic [NUM_CH-1:0] mask;
    logic [NUM_CH-1:0] levels;
    logic [TIME_W-1:0] stamp;
  } edge_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [NUM_CH-1:0]        in_edge_mask = '0;
  logic [NUM_CH-1:0]        in_pin_levels = '0;
  logic [TIME_W-1:0]        in_timer_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [TIME_W-1:0] out_throttle;
  logic signed [TIME_W-1:0] out_roll;
  logic signed [TIME_W-1:0] out_pitch;
  logic signed [TIME_W-1:0] out_yaw;
  logic [1:0]               out_switch_position;
  logic                     out_auto_mode;
  logic                     out_disarm_request;
  logic                     cfg_we = 1'b0;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;

  rc_pwm_six_channel_decoder u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_edge_mask        (in_edge_mask),
    .in_pin_levels       (in_pin_levels),
    .in_timer_value      (in_timer_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_throttle        (out_throttle),
    .out_roll            (out_roll),
    .out_pitch           (out_pitch),
    .out_yaw             (out_yaw),
    .out_switch_position (out_switch_position),
    .out_auto_mode       (out_auto_mode),
    .out_disarm_request  (out_disarm_request),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the decoder: registers, per-lane timestamps and widths
  cfg_t              cfg_model = '{MIN_PULSE_RST, MID_PULSE_RST, YAW_DEADBAND_RST,
                                   SWITCH_OFFSET_RST};
  logic [TIME_W-1:0] lane_stamp [NUM_CH];
  logic [TIME_W-1:0] lane_width [NUM_CH];

  edge_event_t edge_events_pending [$];
  result_t     controls_expected [$];

  // Stimulus-side tracking of what each pin was last told
  logic [NUM_CH-1:0] stim_level = '0;
  logic [TIME_W-1:0] stim_last [NUM_CH];
  logic [TIME_W-1:0] stim_now = 32'hFFFF_FFFF;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int events_sent = 0;
  int results_checked = 0;
  int settings_used = 1;

  initial begin
    for (int i = 0; i < NUM_CH; i++) begin
      lane_stamp[i] = '0;
      lane_width[i] = '0;
      stim_last[i] = '0;
    end
  end

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH: %s", msg);
  endtask

  // Update the shadow lanes with one edge event and queue the decoded controls
  task automatic capture_event(input logic [NUM_CH-1:0] edges, input logic [NUM_CH-1:0] levels,
                               input logic [TIME_W-1:0] now);
    result_t           r;
    logic [TIME_W-1:0] min_w;
    logic [TIME_W-1:0] mid_w;
    logic [TIME_W-1:0] off_w;
    int                yaw_s;
    int                band;
    min_w = {16'b0, cfg_model.min_pulse};
    mid_w = {16'b0, cfg_model.mid_pulse};
    off_w = {16'b0, cfg_model.switch_offset};
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (edges[ch]) begin
        // falling edge closes the pulse before the stamp moves
        if (!levels[ch]) lane_width[ch] = lane_stamp[ch] - now;
        lane_stamp[ch] = now;
      end
    end
    r.throttle = lane_width[CH_THR] - min_w;
    r.roll     = 32'd0 - (lane_width[CH_ROLL] - mid_w);
    r.pitch    = lane_width[CH_PITCH] - mid_w;
    r.yaw      = lane_width[CH_YAW] - mid_w;
    yaw_s = r.yaw;
    band  = int'(cfg_model.yaw_deadband);
    if (yaw_s < band && yaw_s > -band) r.yaw = '0;
    if (lane_width[CH_SWITCH] < min_w + off_w) r.switch_position = SW_POS_3;
    else if (lane_width[CH_SWITCH] < mid_w + off_w) r.switch_position = SW_POS_2;
    else r.switch_position = SW_POS_1;
    r.auto_mode = (lane_width[CH_MODE] > mid_w) ? 1'b0 : 1'b1;
    r.disarm_request = (r.switch_position == SW_POS_1) && (lane_width[CH_THR] <= min_w);
    controls_expected.push_back(r);
  endtask

  // Driver: one transfer per handshake, random gaps between items
  always @(posedge clk) begin : drive_events
    edge_event_t ev;
    logic        holding;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      holding = in_valid;
      if (in_valid && in_ready) begin
        capture_event(in_edge_mask, in_pin_levels, in_timer_value);
        events_sent++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (edge_events_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          ev = edge_events_pending.pop_front();
          in_valid       <= 1'b1;
          in_edge_mask   <= ev.mask;
          in_pin_levels  <= ev.levels;
          in_timer_value <= ev.stamp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [TIME_W-1:0] exp_v,
                             input logic [TIME_W-1:0] act_v);
    if (exp_v !== act_v)
      flag_error($sformatf("result %0d %s: expected %h, got %h", results_checked, name,
                           exp_v, act_v));
  endtask

  // Monitor: compare each result transfer against the oldest prediction
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (controls_expected.size() == 0) begin
          flag_error($sformatf("result %0d arrived with no edge event outstanding",
                               results_checked));
        end else begin
          want = controls_expected.pop_front();
          check_field("throttle", want.throttle, out_throttle);
          check_field("roll", want.roll, out_roll);
          check_field("pitch", want.pitch, out_pitch);
          check_field("yaw", want.yaw, out_yaw);
          check_field("switch_position", TIME_W'(want.switch_position),
                      TIME_W'(out_switch_position));
          check_field("auto_mode", TIME_W'(want.auto_mode), TIME_W'(out_auto_mode));
          check_field("disarm_request", TIME_W'(want.disarm_request),
                      TIME_W'(out_disarm_request));
        end
        results_checked++;
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Queue one edge event and track the pin state it implies
  task automatic post_event(input logic [NUM_CH-1:0] mask, input logic [NUM_CH-1:0] levels,
                            input logic [TIME_W-1:0] now);
    edge_event_t ev;
    ev.mask = mask;
    ev.levels = levels;
    ev.stamp = now;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (mask[ch]) begin
        stim_last[ch] = now;
        stim_level[ch] = levels[ch];
      end
    end
    stim_now = now;
    edge_event_t_push(ev);
  endtask

  task automatic edge_event_t_push(input edge_event_t ev);
    edge_events_pending.push_back(ev);
  endtask

  // Rising then falling edge on one channel, giving the requested width
  task automatic post_pulse(input int ch, input logic [TIME_W-1:0] start,
                            input logic [TIME_W-1:0] width);
    logic [NUM_CH-1:0] bit_ch;
    bit_ch = 6'b1 << ch;
    post_event(bit_ch, bit_ch, start);
    post_event(bit_ch, ~bit_ch, start - width);
  endtask

  // Pulse widths clustered on the decode thresholds of the current settings, or random
  function automatic logic [TIME_W-1:0] pulse_target();
    int jit;
    jit = int'($urandom_range(0, 16)) - 8;
    case ($urandom_range(0, 7))
      0: return {16'b0, cfg_model.min_pulse} + jit;
      1: return {16'b0, cfg_model.mid_pulse} + jit;
      2: return {16'b0, cfg_model.min_pulse} + {16'b0, cfg_model.switch_offset} + jit;
      3: return {16'b0, cfg_model.mid_pulse} + {16'b0, cfg_model.switch_offset} + jit;
      4: return {16'b0, cfg_model.mid_pulse} + {16'b0, cfg_model.yaw_deadband} + jit;
      5: return {16'b0, cfg_model.mid_pulse} - {16'b0, cfg_model.yaw_deadband} + jit;
      6: return $urandom;
      default: return $urandom_range(0, 70000);
    endcase
  endfunction

  // Mostly well-formed toggles with targeted widths, some raw noise
  task automatic post_random_event();
    logic [NUM_CH-1:0] mask;
    logic [NUM_CH-1:0] lv;
    logic [TIME_W-1:0] now;
    int                fch;
    if ($urandom_range(0, 99) < 20) begin
      mask = NUM_CH'($urandom);
      lv   = NUM_CH'($urandom);
      now  = $urandom;
    end else begin
      if ($urandom_range(0, 3) != 0) begin
        mask = 6'b1 << $urandom_range(0, NUM_CH - 1);
      end else begin
        mask = NUM_CH'($urandom);
        if (mask == '0) mask = '1;
      end
      lv  = NUM_CH'($urandom);
      fch = -1;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (mask[ch]) begin
          lv[ch] = ~stim_level[ch];
          if (stim_level[ch] && fch < 0) fch = ch;
        end
      end
      if (fch >= 0) now = stim_last[fch] - pulse_target();
      else now = stim_now - $urandom_range(1, 40000);
    end
    post_event(mask, lv, now);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_MIN_PULSE:     cfg_model.min_pulse = val;
      CFG_MID_PULSE:     cfg_model.mid_pulse = val;
      CFG_YAW_DEADBAND:  cfg_model.yaw_deadband = val;
      CFG_SWITCH_OFFSET: cfg_model.switch_offset = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Block is idle once nothing is queued, presented or outstanding
  task automatic wait_drained();
    do @(negedge clk);
    while (edge_events_pending.size() > 0 || in_valid || controls_expected.size() > 0);
  endtask

  // Main sequence: directed events, then paced random phases
  initial begin : run_sequence
    cfg_t s;
    int   k;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: no-edge, all-lane extremes, wrap, rising-only, threshold widths
    post_event(6'h00, 6'h3F, 32'h0000_0000);
    post_event(6'h3F, 6'h3F, 32'hFFFF_FFFF);
    post_event(6'h3F, 6'h00, 32'h0000_0000);
    post_event(6'h3F, 6'h3F, 32'h0000_0000);
    post_event(6'h3F, 6'h00, 32'hFFFF_FFFF);
    post_event(6'h00, 6'h2A, 32'h0000_007B);
    post_event(6'h15, 6'h3F, 32'h0000_1388);
    post_event(6'h3F, 6'h15, 32'h0000_0FA0);
    post_event(6'h2A, 6'h3F, 32'h0000_0FA0);
    post_pulse(CH_ROLL, 32'h0010_0000, TIME_W'(MID_PULSE_RST));
    post_pulse(CH_PITCH, 32'h0020_0000, MID_PULSE_RST + 1);
    post_pulse(CH_THR, 32'h0000_1000, TIME_W'(MIN_PULSE_RST));
    post_pulse(CH_YAW, 32'h0030_0000, MID_PULSE_RST + YAW_DEADBAND_RST - 1);
    post_pulse(CH_SWITCH, 32'h0040_0000, TIME_W'(MID_PULSE_RST + SWITCH_OFFSET_RST));
    post_pulse(CH_MODE, 32'h0050_0000, MID_PULSE_RST + 1);
    post_pulse(CH_YAW, 32'h0060_0000, TIME_W'(MID_PULSE_RST - YAW_DEADBAND_RST));
    post_pulse(CH_SWITCH, 32'h0070_0000, MIN_PULSE_RST + SWITCH_OFFSET_RST - 1);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0, 7: s = '{MIN_PULSE_RST, MID_PULSE_RST, YAW_DEADBAND_RST, SWITCH_OFFSET_RST};
        1: s = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
        2: s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        3: s = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
        5: s = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000};
        default: s = '{CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom_range(0, 8192)),
                       CFG_W'($urandom)};
      endcase
      write_reg(CFG_MIN_PULSE, s.min_pulse);
      write_reg(CFG_MID_PULSE, s.mid_pulse);
      write_reg(CFG_YAW_DEADBAND, s.yaw_deadband);
      write_reg(CFG_SWITCH_OFFSET, s.switch_offset);
      settings_used++;
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      for (k = 0; k < 192; k++) begin
        post_random_event();
        // sender holds off mid-phase until every result is back
        if (ph == 2 && k == 95) wait_drained();
      end
      wait_drained();
    end

    // final drain with a bound, then watch for stray results
    do @(negedge clk);
    while (edge_events_pending.size() > 0 || in_valid);
    for (k = 0; k < 1000 && controls_expected.size() > 0; k++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (controls_expected.size() > 0)
      flag_error($sformatf("%0d predicted results never arrived", controls_expected.size()));

    $display("Covered %0d edge events and %0d decoded results over %0d register settings,",
             events_sent, results_checked, settings_used);
    $display("with free-running, sender-gapped, receiver-stalled and mixed pacing; %0d errors.",
             fail_count);
    if (fail_count == 0) begin
      $display("[rc_pwm_six_channel_decoder] OK");
    end else begin
      $display("[rc_pwm_six_channel_decoder] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("Timeout: simulation did not complete");
    $display("[rc_pwm_six_channel_decoder] ERROR");
    $finish;
  end

endmodule
